// ===== rtl/core/cosine_top_k_matcher_unit_defines.svh =====
// Assertion macros for the cosine top-K matcher
`ifndef COSINE_TOP_K_MATCHER_UNIT_DEFINES_SVH
`define COSINE_TOP_K_MATCHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: label");
`define CTK_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define CTK_ASSERT(label, clk, rst_n, prop)
`define CTK_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/ctkm_pkg.sv =====
// ----------------------------------------------------------------------------
// ctkm_pkg
// Shared widths and types of the cosine top-K matcher.
// ----------------------------------------------------------------------------
package ctkm_pkg;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned ScoreW  = 16;
  localparam int unsigned RankW   = 3;
  localparam int unsigned DotW    = 40;
  localparam int unsigned EnergyW = 39;
  localparam int unsigned RootW   = 20;
  localparam int unsigned DenW    = 40;
  localparam int unsigned NumW    = 55;
  localparam int unsigned QuotW   = 17;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [TagW-1:0]          tag_t;

  // handshake between the score unit and the top level
  typedef struct packed {
    logic   done;
    score_t score;
  } score_ctl_t;
endpackage

// ===== rtl/core/ctkm_accum.sv =====
// ----------------------------------------------------------------------------
// ctkm_accum
// Saturating accumulators of dot product and both energies.
// ----------------------------------------------------------------------------
module ctkm_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                clr_i,
  input  logic signed [ctkm_pkg::ElemW-1:0]   q_i,
  input  logic signed [ctkm_pkg::ElemW-1:0]   c_i,
  output logic signed [ctkm_pkg::DotW-1:0]    dot_o,
  output logic [ctkm_pkg::EnergyW-1:0]        eq_o,
  output logic [ctkm_pkg::EnergyW-1:0]        ec_o
);
  import ctkm_pkg::*;

  logic signed [DotW-1:0] dot_q, dot_d;
  logic [EnergyW-1:0] eq_q, eq_d, ec_q, ec_d;
  logic signed [DotW:0] dsum;
  logic [EnergyW:0] esq, esc;
  logic signed [2*ElemW-1:0] pqc, pqq, pcc;
  localparam logic signed [DotW:0] DMax = {2'b00, {(DotW-1){1'b1}}};
  localparam logic signed [DotW:0] DMin = {2'b11, {(DotW-1){1'b0}}};

  always_comb begin
    pqc  = q_i * c_i;
    pqq  = q_i * q_i;
    pcc  = c_i * c_i;
    dsum = $signed({dot_q[DotW-1], dot_q}) + (DotW+1)'(pqc);
    esq  = {1'b0, eq_q} + (EnergyW+1)'(unsigned'(pqq));
    esc  = {1'b0, ec_q} + (EnergyW+1)'(unsigned'(pcc));
    if (dsum > DMax)      dot_d = DMax[DotW-1:0];
    else if (dsum < DMin) dot_d = DMin[DotW-1:0];
    else                  dot_d = dsum[DotW-1:0];
    eq_d = esq[EnergyW] ? {EnergyW{1'b1}} : esq[EnergyW-1:0];
    ec_d = esc[EnergyW] ? {EnergyW{1'b1}} : esc[EnergyW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; eq_q <= '0; ec_q <= '0;
    end else if (clr_i) begin
      dot_q <= '0; eq_q <= '0; ec_q <= '0;
    end else if (en_i) begin
      dot_q <= dot_d; eq_q <= eq_d; ec_q <= ec_d;
    end
  end

  assign dot_o = dot_q;
  assign eq_o  = eq_q;
  assign ec_o  = ec_q;
endmodule

// ===== rtl/core/ctkm_score.sv =====
// ----------------------------------------------------------------------------
// ctkm_score
// Cosine score: two bit-serial roots and a bit-serial divide on one shared
// subtract unit, plus one multiply, under a small sequencer.
// ----------------------------------------------------------------------------
`include "cosine_top_k_matcher_unit_defines.svh"
module ctkm_score (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ctkm_pkg::DotW-1:0]   dot_i,
  input  logic [ctkm_pkg::EnergyW-1:0]       eq_i,
  input  logic [ctkm_pkg::EnergyW-1:0]       ec_i,
  output ctkm_pkg::score_ctl_t               ctl_o
);
  import ctkm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SQQ = 6'b000010, S_SQC = 6'b000100,
    S_MUL  = 6'b001000, S_DIV = 6'b010000, S_FIN = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [EnergyW+1:0] rad_q, rad_d;      // remaining radicand bits
  logic [RootW+1:0] rem_q, rem_d;        // root remainder
  logic [RootW-1:0] root_q, root_d, mq_q, mq_d;
  logic [DenW-1:0] den_q, den_d;
  logic [NumW-1:0] num_q, num_d;
  logic [QuotW-1:0] quo_q, quo_d;
  logic neg_q, neg_d, zero_q, zero_d;
  logic [DenW:0] drem_q, drem_d;
  score_t score_q, score_d;

  // shared subtract unit
  logic [DenW+1:0] sub_a, sub_b, sub_r;
  logic sub_ge;
  logic [RootW+1:0] trial;
  logic [DenW:0] dtrial;
  logic [DotW-1:0] mag;

  always_comb begin
    mag    = dot_i[DotW-1] ? DotW'(-dot_i) : DotW'(dot_i);
    trial  = {rem_q[RootW-1:0], rad_q[EnergyW+1:EnergyW]};
    dtrial = {drem_q[DenW-1:0], num_q[NumW-1]};
    if (state_q == S_DIV) begin
      sub_a = {1'b0, dtrial};
      sub_b = {2'b00, den_q};
    end else begin
      sub_a = (DenW+2)'(trial);
      sub_b = (DenW+2)'({root_q, 2'b01});
    end
    sub_r  = sub_a - sub_b;
    sub_ge = !sub_r[DenW+1];

    state_d = state_q; cnt_d = cnt_q; rad_d = rad_q; rem_d = rem_q;
    root_d = root_q; mq_d = mq_q; den_d = den_q; num_d = num_q;
    quo_d = quo_q; neg_d = neg_q; zero_d = zero_q; drem_d = drem_q;
    score_d = score_q;
    case (state_q)
      S_IDLE: if (start_i) begin
        state_d = S_SQQ; cnt_d = '0;
        // pad to an even bit count so the last step takes the two lowest bits
        rad_d = {1'b0, eq_i, 1'b0};
        rem_d = '0; root_d = '0;
        neg_d = dot_i[DotW-1];
        zero_d = (eq_i == '0) || (ec_i == '0);
        num_d = {mag, 15'b0};
      end
      S_SQQ, S_SQC: begin
        if (sub_ge) begin
          rem_d = sub_r[RootW+1:0]; root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d = trial; root_d = {root_q[RootW-2:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(RootW-1)) begin
          cnt_d = '0; rem_d = '0; root_d = '0;
          if (state_q == S_SQQ) begin
            mq_d = sub_ge ? {root_q[RootW-2:0], 1'b1} : {root_q[RootW-2:0], 1'b0};
            rad_d = {1'b0, ec_i, 1'b0};
            state_d = S_SQC;
          end else begin
            // hold the candidate root for the multiply
            root_d = sub_ge ? {root_q[RootW-2:0], 1'b1} : {root_q[RootW-2:0], 1'b0};
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        drem_d = '0; quo_d = '0; cnt_d = '0;
        den_d = DenW'(mq_q * root_q);
        if (zero_q) begin
          score_d = '0; state_d = S_FIN;
        end else state_d = S_DIV;
      end
      S_DIV: begin
        // restoring divide; saturate once the quotient exceeds 16 bits
        if (sub_ge) drem_d = sub_r[DenW:0];
        else        drem_d = dtrial;
        quo_d = quo_q[QuotW-1] ? quo_q : {quo_q[QuotW-2:0], sub_ge};
        num_d = num_q << 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NumW-1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (state_q == S_FIN && !zero_q && den_q != '0) begin
          if (neg_q) score_d = (quo_q >= 17'd32768) ? score_t'(-32768)
                                                    : score_t'(-quo_q);
          else       score_d = (quo_q > 17'd32767) ? score_t'(32767)
                                                   : score_t'(quo_q);
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d; mq_q <= mq_d;
    den_q <= den_d; num_q <= num_d; quo_q <= quo_d; neg_q <= neg_d;
    zero_q <= zero_d; drem_q <= drem_d; score_q <= score_d;
  end

  assign ctl_o.done  = (state_q == S_FIN);
  assign ctl_o.score = score_d;

  `CTK_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> state_q == S_IDLE)
  `CTK_ASSERT(a_fin_idle, clk_i, rst_ni, state_q == S_FIN |=> state_q == S_IDLE)
  `CTK_ASSERT(a_start_sq, clk_i, rst_ni, start_i |=> state_q == S_SQQ)
endmodule

// ===== rtl/core/ctkm_topk.sv =====
// ----------------------------------------------------------------------------
// ctkm_topk
// Sorted top list with one compare-and-shift insert per cycle of the
// sequencer; read port for emitting ranks.
// ----------------------------------------------------------------------------
module ctkm_topk #(
  parameter int unsigned TopCount = 5
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               ins_i,
  input  ctkm_pkg::score_t                                   score_i,
  input  ctkm_pkg::tag_t                                     tag_i,
  input  logic [((TopCount > 1) ? $clog2(TopCount) : 1)-1:0] rd_idx_i,
  output ctkm_pkg::score_t                                   rd_score_o,
  output ctkm_pkg::tag_t                                     rd_tag_o
);
  import ctkm_pkg::*;

  score_t scores_q [TopCount];
  tag_t   tags_q   [TopCount];
  logic [TopCount-1:0] gt;

  always_comb begin
    for (int i = 0; i < TopCount; i++) gt[i] = score_i > scores_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TopCount; i++) begin
        scores_q[i] <= '0; tags_q[i] <= '0;
      end
    end else if (ins_i) begin
      for (int i = 0; i < TopCount; i++) begin
        if (gt[i]) begin
          if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
            scores_q[i] <= score_i; tags_q[i] <= tag_i;
          end else begin
            scores_q[i] <= scores_q[(i == 0) ? 0 : i-1];
            tags_q[i]   <= tags_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  assign rd_score_o = scores_q[rd_idx_i];
  assign rd_tag_o   = tags_q[rd_idx_i];
endmodule

// ===== rtl/core/cosine_top_k_matcher_unit.sv =====
// An element without last is taken back to back. A last element is scored
// (start, two 20-step roots, one multiply, a 55-step divide, finish) and then
// inserted; the first of TOP_COUNT result items is offered after the insert.
// When a magnitude is zero the divide is skipped. The next element is taken
// only after the last result item is accepted, so sink stalls hold it back.
// ----------------------------------------------------------------------------
// cosine_top_k_matcher_unit
// Streams element pairs, scores each entry by cosine and keeps a top list.
// Reset clears the sums and the top list to zero scores and tags.
// ----------------------------------------------------------------------------
`include "cosine_top_k_matcher_unit_defines.svh"
module cosine_top_k_matcher_unit #(
  parameter int unsigned TOP_COUNT = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // query_element, candidate_element, entry_tag
  input  logic        s_axis_tlast,  // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // rank, match_tag, match_score, slot_valid, pad
  output logic        m_axis_tlast   // last_result
);
  import ctkm_pkg::*;

  localparam int unsigned IdxW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  typedef enum logic [3:0] {
    T_ACC = 4'b0001, T_SCORE = 4'b0010, T_INS = 4'b0100, T_OUT = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  tag_t tag_q;
  logic acc_en, start;
  logic signed [DotW-1:0] dot;
  logic [EnergyW-1:0] eq, ec;
  score_ctl_t sctl;
  score_t score_q, rd_score;
  tag_t rd_tag;

  assign s_axis_tready = (state_q == T_ACC);
  assign acc_en = s_axis_tvalid && s_axis_tready;
  assign start  = (state_q == T_SCORE) && (idx_q == '0);

  ctkm_accum u_acc (
    .clk_i, .rst_ni, .en_i(acc_en), .clr_i(state_q == T_INS),
    .q_i(s_axis_tdata[15:0]), .c_i(s_axis_tdata[31:16]),
    .dot_o(dot), .eq_o(eq), .ec_o(ec)
  );

  ctkm_score u_score (
    .clk_i, .rst_ni, .start_i(start), .dot_i(dot), .eq_i(eq), .ec_i(ec),
    .ctl_o(sctl)
  );

  ctkm_topk #(.TopCount(TOP_COUNT)) u_topk (
    .clk_i, .rst_ni, .ins_i(state_q == T_INS), .score_i(score_q), .tag_i(tag_q),
    .rd_idx_i(idx_q), .rd_score_o(rd_score), .rd_tag_o(rd_tag)
  );

  always_comb begin
    state_d = state_q; idx_d = idx_q;
    case (state_q)
      T_ACC:   if (acc_en && s_axis_tlast) begin state_d = T_SCORE; idx_d = '0; end
      T_SCORE: begin
        idx_d = IdxW'(1);
        if (sctl.done) begin state_d = T_INS; idx_d = '0; end
      end
      T_INS:   state_d = T_OUT;
      T_OUT:   if (m_axis_tready) begin
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(TOP_COUNT - 1)) begin state_d = T_ACC; idx_d = '0; end
      end
      default: state_d = T_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_ACC; idx_q <= '0;
    end else begin
      state_q <= state_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) tag_q <= s_axis_tdata[47:32];
    if (sctl.done) score_q <= sctl.score;
  end

  assign m_axis_tvalid = (state_q == T_OUT);
  assign m_axis_tlast  = (idx_q == IdxW'(TOP_COUNT - 1));
  assign m_axis_tdata  = {4'b0, (rd_score > 0), rd_score, rd_tag, RankW'(idx_q)};

  `CTK_ASSERT(a_no_in_busy, clk_i, rst_ni, state_q != T_ACC |-> !s_axis_tready)
  `CTK_ASSERT(a_out_idx, clk_i, rst_ni, m_axis_tvalid |-> idx_q <= IdxW'(TOP_COUNT - 1))
  `CTK_ASSERT(a_ins_out, clk_i, rst_ni, state_q == T_INS |=> m_axis_tvalid)
endmodule
